FILE: rtl/mi3_pkg.sv
// mi3_pkg: widths, index tables and types for the 3x3 matrix inverse pipeline.
// No dependencies; imported by matrix3_inverse and tb_top.
`timescale 1ns / 1ps

package mi3_pkg;

    // fixed-point format of the elements
    localparam int FRAC_BITS  = 16;
    localparam int ELEM_W     = 32;
    localparam int N_ELEM     = 9;
    localparam int DATA_W     = ELEM_W * N_ELEM;
    localparam int THR_W      = 31;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

    // intermediate widths
    localparam int PROD_W     = 2 * ELEM_W;             // element product / cofactor
    localparam int LO_W       = PROD_W + 1;             // element times low cofactor half
    localparam int TERM_W     = ELEM_W + PROD_W;        // element times cofactor
    localparam int DET_W      = TERM_W + 2;             // sum of three terms
    localparam int NUM_W      = PROD_W + 2 * FRAC_BITS; // |cofactor| << 2F
    localparam int Q_W        = ELEM_W + 2;             // quotient bits incl. overflow bit
    localparam int DIV_STAGES = Q_W;
    localparam int DEN_W      = DET_W + Q_W - 1;        // widest shifted divisor

    // saturation limits, 33 bits wide
    localparam logic [ELEM_W:0] LIM_POS = {2'b00, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W:0] LIM_NEG = {2'b01, {(ELEM_W-1){1'b0}}};

    // cofactor k = m[PA_X]*m[PA_Y] - m[PB_X]*m[PB_Y]
    localparam logic [3:0] PA_X [0:N_ELEM-1] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
    localparam logic [3:0] PA_Y [0:N_ELEM-1] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
    localparam logic [3:0] PB_X [0:N_ELEM-1] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam logic [3:0] PB_Y [0:N_ELEM-1] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

    // one element lane of the divider
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   quo;
        logic             neg;
    } div_lane_t;

endpackage

FILE: rtl/matrix3_inverse.sv
// matrix3_inverse: pipelined 3x3 matrix inverse by adjugate over determinant.
// Depends on mi3_pkg (widths, cofactor index tables, divider lane type).
// ---------------------------------------------------------------------------
// Usage
//   s_* : one row-major 3x3 matrix per transaction, nine signed Q16.16 words.
//   m_* : one transaction per input: the inverse, or the input unchanged with
//         m_tuser set when |det| is below the threshold (or det is zero).
//   cfg_we/cfg_wdata : writes the singular threshold (Q16.16 magnitude);
//         write only while the pipeline is empty.
// Pipeline: 42 register stages: 7 stages of products, cofactors,
//   determinant, magnitude and singular decision, 34 stages of restoring
//   division (one quotient bit per stage, nine lanes in parallel), one stage
//   for saturation and output select.
// Throughput: one matrix per cycle while no stall holds the pipeline; every
//   stage is registered and carries a valid bit.
// Reset: empties the pipeline and loads the threshold with 7.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready is low; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3_inverse (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mi3_pkg::DATA_W-1:0]   s_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mi3_pkg::DATA_W-1:0]   m_tdata,   // b00,b01,b02,b10,b11,b12,b20,b21,b22
    output logic                         m_tuser,   // singular
    input  logic                         cfg_we,
    input  logic [mi3_pkg::THR_W-1:0]    cfg_wdata  // singular_threshold
);
    import mi3_pkg::*;

    localparam int N_STG = 8;  // stages 1..7 plus output stage

    logic en;
    logic [THR_W-1:0] thr_reg;
    logic [N_STG-1:0] vld_reg, vld_next;
    logic div_vld_reg [0:DIV_STAGES-1];

    logic signed [ELEM_W-1:0] a_in [0:N_ELEM-1];

    // stage 1: element products
    logic signed [ELEM_W-1:0] a1_reg [0:N_ELEM-1];
    logic signed [PROD_W-1:0] pa_reg [0:N_ELEM-1], pa_next [0:N_ELEM-1];
    logic signed [PROD_W-1:0] pb_reg [0:N_ELEM-1], pb_next [0:N_ELEM-1];
    // stage 2: cofactors
    logic signed [ELEM_W-1:0] a2_reg [0:N_ELEM-1];
    logic signed [PROD_W-1:0] c_reg [0:N_ELEM-1], c_next [0:N_ELEM-1];
    // stage 3: split determinant products, cofactor magnitudes
    logic signed [ELEM_W-1:0] a3_reg [0:N_ELEM-1];
    logic signed [LO_W-1:0]   lo_reg [0:2], lo_next [0:2];
    logic signed [PROD_W-1:0] hi_reg [0:2], hi_next [0:2];
    logic [PROD_W-1:0]        cm3_reg [0:N_ELEM-1], cm3_next [0:N_ELEM-1];
    logic                     cn3_reg [0:N_ELEM-1];
    // stage 4: determinant terms
    logic signed [ELEM_W-1:0] a4_reg [0:N_ELEM-1];
    logic [PROD_W-1:0]        cm4_reg [0:N_ELEM-1];
    logic                     cn4_reg [0:N_ELEM-1];
    logic [DET_W-1:0]         t_reg [0:2], t_next [0:2];
    // stage 5: determinant
    logic signed [ELEM_W-1:0] a5_reg [0:N_ELEM-1];
    logic [PROD_W-1:0]        cm5_reg [0:N_ELEM-1];
    logic                     cn5_reg [0:N_ELEM-1];
    logic [DET_W-1:0]         det_reg, det_next;
    // stage 6: determinant magnitude
    logic signed [ELEM_W-1:0] a6_reg [0:N_ELEM-1];
    logic [PROD_W-1:0]        cm6_reg [0:N_ELEM-1];
    logic                     cn6_reg [0:N_ELEM-1];
    logic [DET_W-1:0]         dmag6_reg, dmag6_next;
    logic                     dneg6_reg;
    // stage 7: singular decision, quotient signs
    logic signed [ELEM_W-1:0] a7_reg [0:N_ELEM-1];
    logic [PROD_W-1:0]        cm7_reg [0:N_ELEM-1];
    logic                     neg7_reg [0:N_ELEM-1], neg7_next [0:N_ELEM-1];
    logic [DET_W-1:0]         dmag7_reg;
    logic                     sing7_reg, sing7_next;
    // divider stages
    logic signed [ELEM_W-1:0] ad_reg [0:DIV_STAGES-1][0:N_ELEM-1];
    div_lane_t                ln_reg [0:DIV_STAGES-1][0:N_ELEM-1];
    div_lane_t                ln_next [0:DIV_STAGES-1][0:N_ELEM-1];
    logic [DET_W-1:0]         dmagd_reg [0:DIV_STAGES-1];
    logic                     singd_reg [0:DIV_STAGES-1];
    // output stage
    logic [DATA_W-1:0]        out_reg, out_next;
    logic                     usr_reg;

    // pipeline advances unless the output holds an untaken transaction
    assign en       = !vld_reg[N_STG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[N_STG-1];
    assign m_tdata  = out_reg;
    assign m_tuser  = usr_reg;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // valid bits: stages 1..7 shift, output stage fed by last divider stage
    always_comb
    begin
        vld_next[0] = s_tvalid;
        for (int i = 1; i < N_STG - 1; i++)
            vld_next[i] = vld_reg[i-1];
        vld_next[N_STG-1] = div_vld_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            for (int j = 0; j < DIV_STAGES; j++)
                div_vld_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
            div_vld_reg[0] <= vld_reg[N_STG-2];
            for (int j = 1; j < DIV_STAGES; j++)
                div_vld_reg[j] <= div_vld_reg[j-1];
        end
    end

    // unpack input
    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
            a_in[k] = $signed(s_tdata[k*ELEM_W +: ELEM_W]);
    end

    // stages 1..7 combinational
    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            pa_next[k] = PROD_W'(a_in[PA_X[k]] * a_in[PA_Y[k]]);
            pb_next[k] = PROD_W'(a_in[PB_X[k]] * a_in[PB_Y[k]]);
            c_next[k]  = pa_reg[k] - pb_reg[k];
            cm3_next[k] = c_reg[k][PROD_W-1] ? PROD_W'(-c_reg[k]) : c_reg[k];
            neg7_next[k] = cn6_reg[k] ^ dneg6_reg;
        end
        // det = sum over j of m[3j] * c[3j], cofactor split in 32-bit halves
        for (int j = 0; j < 3; j++)
        begin
            lo_next[j] = LO_W'(a2_reg[3*j] * $signed({1'b0, c_reg[3*j][ELEM_W-1:0]}));
            hi_next[j] = PROD_W'(a2_reg[3*j] * $signed(c_reg[3*j][PROD_W-1:ELEM_W]));
            t_next[j]  = {{(DET_W-TERM_W){hi_reg[j][PROD_W-1]}}, hi_reg[j], {ELEM_W{1'b0}}}
                       + {{(DET_W-LO_W){lo_reg[j][LO_W-1]}}, lo_reg[j]};
        end
        det_next   = t_reg[0] + t_reg[1] + t_reg[2];
        dmag6_next = det_reg[DET_W-1] ? DET_W'(-det_reg) : det_reg;
        sing7_next = (dmag6_reg == '0)
                   || (dmag6_reg < DET_W'({thr_reg, {(2*FRAC_BITS){1'b0}}}));
    end

    // stages 1..7 registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a_in;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            a2_reg <= a1_reg;
            c_reg  <= c_next;
            a3_reg <= a2_reg;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            cm3_reg <= cm3_next;
            for (int k = 0; k < N_ELEM; k++)
                cn3_reg[k] <= c_reg[k][PROD_W-1];
            a4_reg  <= a3_reg;
            cm4_reg <= cm3_reg;
            cn4_reg <= cn3_reg;
            t_reg   <= t_next;
            a5_reg  <= a4_reg;
            cm5_reg <= cm4_reg;
            cn5_reg <= cn4_reg;
            det_reg <= det_next;
            a6_reg  <= a5_reg;
            cm6_reg <= cm5_reg;
            cn6_reg <= cn5_reg;
            dmag6_reg <= dmag6_next;
            dneg6_reg <= det_reg[DET_W-1];
            a7_reg  <= a6_reg;
            cm7_reg <= cm6_reg;
            neg7_reg <= neg7_next;
            dmag7_reg <= dmag6_reg;
            sing7_reg <= sing7_next;
        end
    end

    // restoring division, one quotient bit per stage, MSB (overflow bit) first
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        localparam int SH = Q_W - 1 - j;
        div_lane_t        lin [0:N_ELEM-1];
        logic [DET_W-1:0] dmag_in;

        always_comb
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                if (j == 0)
                begin
                    lin[k].rem = {cm7_reg[k], {(2*FRAC_BITS){1'b0}}};
                    lin[k].quo = '0;
                    lin[k].neg = neg7_reg[k];
                end
                else
                    lin[k] = ln_reg[(j == 0) ? 0 : j-1][k];
            end
            dmag_in = (j == 0) ? dmag7_reg : dmagd_reg[(j == 0) ? 0 : j-1];
        end

        for (genvar k = 0; k < N_ELEM; k++)
        begin : g_lane
            logic [DEN_W-1:0] den;
            logic             ge;
            always_comb
            begin
                den = DEN_W'(dmag_in) << SH;
                ge  = DEN_W'(lin[k].rem) >= den;
                ln_next[j][k] = lin[k];
                if (ge)
                begin
                    ln_next[j][k].rem = lin[k].rem - den[NUM_W-1:0];
                    ln_next[j][k].quo[SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ln_reg[j] <= ln_next[j];
                dmagd_reg[j] <= dmag_in;
                if (j == 0)
                begin
                    ad_reg[j] <= a7_reg;
                    singd_reg[j] <= sing7_reg;
                end
                else
                begin
                    ad_reg[j] <= ad_reg[(j == 0) ? 0 : j-1];
                    singd_reg[j] <= singd_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    // saturation, sign and pass-through select; result is transposed
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                div_lane_t       l;
                logic [ELEM_W:0] lim;
                logic [ELEM_W:0] mag;
                logic            ovf;
                l   = ln_reg[DIV_STAGES-1][c*3 + r];
                lim = l.neg ? LIM_NEG : LIM_POS;
                ovf = l.quo[Q_W-1] || (l.quo[Q_W-2:0] > lim);
                mag = ovf ? lim : l.quo[Q_W-2:0];
                if (singd_reg[DIV_STAGES-1])
                    out_next[(r*3 + c)*ELEM_W +: ELEM_W] = ad_reg[DIV_STAGES-1][r*3 + c];
                else
                    out_next[(r*3 + c)*ELEM_W +: ELEM_W] =
                        l.neg ? ELEM_W'(-mag) : mag[ELEM_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
            usr_reg <= singd_reg[DIV_STAGES-1];
        end
    end

`ifndef NO_ASSERTIONS
    // a held output blocks the input side
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // an accepted transaction enters stage one
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transaction lost at stage one");

    // during a stall the early valid bits do not move
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

    // a transaction leaving the divider reaches the output register
    a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (en && div_vld_reg[DIV_STAGES-1]) |=> m_tvalid)
        else $error("divider result dropped");
`endif

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for matrix3_inverse (3x3 fixed-point inverse).
// Depends on mi3_pkg and matrix3_inverse; predicts each result with its own model.
`timescale 1ns / 1ps

module tb_top;
    import mi3_pkg::*;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct {
        logic [DATA_W-1:0] mat;
        logic              sing;
    } inv_result_t;

    // directed stimulus row: matrix, optional typed-in expectation
    typedef struct {
        logic [DATA_W-1:0] mat;
        logic              has_exp;
        inv_result_t       exp;
    } vec_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    logic [THR_W-1:0] thr_shadow;
    inv_result_t inverse_q[$];
    int n_errors;
    int n_results;
    int n_singular;
    int n_sent;
    int src_idle_pct;
    int snk_idle_pct;
    logic hold_off;
    vec_row_t vec_table[$];

    matrix3_inverse DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(50_000_000);
        $display("timeout at %0t", $time);
        $display("tb_top NOT OK");
        $finish;
    end

    // inverse predictor: exact cofactors and determinant, truncating division
    function automatic inv_result_t predict_inverse(logic [DATA_W-1:0] mat,
                                                    logic [THR_W-1:0] thr);
        logic signed [63:0]  e [9];
        logic signed [63:0]  cof [9];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [127:0]        thr_w;
        logic [127:0]        num;
        logic [127:0]        quo;
        logic                neg;
        logic [31:0]         lim;
        inv_result_t         res;
        for (int k = 0; k < 9; k++)
            e[k] = 64'(signed'(mat[k*ELEM_W +: ELEM_W]));
        cof[0] = e[4]*e[8] - e[5]*e[7];
        cof[1] = e[5]*e[6] - e[3]*e[8];
        cof[2] = e[3]*e[7] - e[4]*e[6];
        cof[3] = e[2]*e[7] - e[1]*e[8];
        cof[4] = e[0]*e[8] - e[2]*e[6];
        cof[5] = e[1]*e[6] - e[0]*e[7];
        cof[6] = e[1]*e[5] - e[2]*e[4];
        cof[7] = e[2]*e[3] - e[0]*e[5];
        cof[8] = e[0]*e[4] - e[1]*e[3];
        det = 128'(e[0])*128'(cof[0]) + 128'(e[3])*128'(cof[3]) + 128'(e[6])*128'(cof[6]);
        dmag = det[127] ? -det : det;
        thr_w = 128'(thr) << (2*FRAC_BITS);
        if (dmag == 0 || dmag < thr_w)
        begin
            res.mat = mat;
            res.sing = 1'b1;
            return res;
        end
        res.sing = 1'b0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                neg = cof[c*3+r][63] ^ det[127];
                num = 128'(cof[c*3+r][63] ? -cof[c*3+r] : cof[c*3+r]);
                num = num << (2*FRAC_BITS);
                quo = num / dmag;
                lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                if (quo > 128'(lim))
                    quo = 128'(lim);
                res.mat[(r*3+c)*ELEM_W +: ELEM_W] = neg ? -quo[31:0] : quo[31:0];
            end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pack_mat(elem_t x0, elem_t x1, elem_t x2,
                                                   elem_t x3, elem_t x4, elem_t x5,
                                                   elem_t x6, elem_t x7, elem_t x8);
        return {x8, x7, x6, x5, x4, x3, x2, x1, x0};
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 5))
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return elem_t'($urandom_range(0, 16)) - 8;
            3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return elem_t'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    // mostly full-rank, some rank-deficient (row copies) and near-singular
    function automatic logic [DATA_W-1:0] rand_matrix();
        elem_t m [9];
        for (int k = 0; k < 9; k++)
            m[k] = rand_elem();
        case ($urandom_range(0, 9))
            0: for (int k = 0; k < 3; k++) m[6+k] = m[k];
            1: for (int k = 0; k < 3; k++) m[3+k] = -m[k];
            2: for (int k = 0; k < 9; k++) m[k] = elem_t'($urandom_range(0, 6)) - 3;
            default: ;
        endcase
        return pack_mat(m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]);
    endfunction

    task automatic send_matrix(logic [DATA_W-1:0] mat);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        inverse_q.push_back(predict_inverse(mat, thr_shadow));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
    endtask

    // wait until the pipeline is empty, then write the threshold
    task automatic write_threshold(logic [THR_W-1:0] val);
        s_tvalid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_shadow = val;
    endtask

    task automatic add_row(logic [DATA_W-1:0] mat, logic has_exp,
                           logic [DATA_W-1:0] emat, logic esing);
        vec_row_t row;
        row.mat = mat;
        row.has_exp = has_exp;
        row.exp.mat = emat;
        row.exp.sing = esing;
        vec_table.push_back(row);
    endtask

    // receiver: random stalls plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (inverse_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                n_errors++;
            end
            else
            begin
                inv_result_t want;
                want = inverse_q.pop_front();
                n_results++;
                if (want.sing)
                    n_singular++;
                for (int k = 0; k < 9; k++)
                    if (m_tdata[k*ELEM_W +: ELEM_W] !== want.mat[k*ELEM_W +: ELEM_W])
                    begin
                        $display("%0t: element %0d expected %h actual %h", $time, k,
                                 want.mat[k*ELEM_W +: ELEM_W], m_tdata[k*ELEM_W +: ELEM_W]);
                        n_errors++;
                    end
                if (m_tuser !== want.sing)
                begin
                    $display("%0t: singular expected %b actual %b", $time,
                             want.sing, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    // long receiver stall so the pipeline fills and backs up
    initial
    begin
        hold_off = 1'b0;
        wait (n_sent >= 200);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    localparam elem_t ONE  = 32'sh0001_0000;
    localparam elem_t TWO  = 32'sh0002_0000;
    localparam elem_t HALF = 32'sh0000_8000;
    localparam elem_t MAXV = 32'sh7FFF_FFFF;
    localparam elem_t MINV = 32'sh8000_0000;

    initial
    begin
        logic [DATA_W-1:0] zero_mat;
        logic [DATA_W-1:0] ident;
        inv_result_t got;
        n_errors = 0;
        n_results = 0;
        n_singular = 0;
        n_sent = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        thr_shadow = THR_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        zero_mat = '0;
        ident = pack_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        // directed table: identity, zero, extremes, saturation, threshold edge
        add_row(ident, 1, ident, 0);
        add_row(zero_mat, 1, zero_mat, 1);
        add_row(pack_mat(TWO, 0, 0, 0, TWO, 0, 0, 0, TWO), 1,
                pack_mat(HALF, 0, 0, 0, HALF, 0, 0, 0, HALF), 0);
        add_row(pack_mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
                pack_mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 0);
        add_row(pack_mat(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 1,
                pack_mat(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 1);
        add_row(pack_mat(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV), 1,
                pack_mat(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV), 1);
        add_row(pack_mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
                pack_mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1);
        add_row(pack_mat(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV), 0, '0, 0);
        add_row(pack_mat(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV), 0, '0, 0);
        add_row(pack_mat(MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, MAXV), 0, '0, 0);
        add_row(pack_mat(16, 0, 0, 0, 16, 0, 0, 0, 16), 0, '0, 0);
        add_row(pack_mat(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 0, '0, 0);
        add_row(pack_mat(ONE, TWO, 3 <<< 16, 4 <<< 16, 5 <<< 16, 6 <<< 16,
                         7 <<< 16, 8 <<< 16, 10 <<< 16), 0, '0, 0);
        add_row(pack_mat(-1, -1, 0, 1, -1, 0, 0, 0, -1), 0, '0, 0);
        add_row(pack_mat(MAXV, MINV, MAXV, MINV, MAXV, MINV, 5, -7, MAXV), 0, '0, 0);

        foreach (vec_table[i])
            send_matrix(vec_table[i].mat);
        s_tvalid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge clk);
        // spot check the typed-in expectations against the predictor itself
        foreach (vec_table[i])
            if (vec_table[i].has_exp)
            begin
                got = predict_inverse(vec_table[i].mat, THR_RESET);
                if (got.mat !== vec_table[i].exp.mat || got.sing !== vec_table[i].exp.sing)
                begin
                    $display("%0t: table row %0d expected %h/%b actual %h/%b", $time, i,
                             vec_table[i].exp.mat, vec_table[i].exp.sing, got.mat, got.sing);
                    n_errors++;
                end
            end

        // random phases over several thresholds, including both extremes
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_threshold('0);
                1: write_threshold({THR_W{1'b1}});
                2: write_threshold(THR_W'($urandom));
                3: write_threshold(THR_W'($urandom_range(0, 32'h0001_0000)));
                4: write_threshold(THR_RESET);
                default: write_threshold(THR_W'(1));
            endcase
            case (ph % 3)
                0: begin src_idle_pct = 14; snk_idle_pct = 57; end
                1: begin src_idle_pct = 57; snk_idle_pct = 14; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int i = 0; i < 180; i++)
                send_matrix(rand_matrix());
        end

        s_tvalid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("%0d matrices sent, %0d results checked (%0d singular)",
                 n_sent, n_results, n_singular);
        $display("thresholds covered zero, full scale, reset value and random values");
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mi3_pkg.sv
rtl/matrix3_inverse.sv
verif/tb_top.sv
